>>> design/lprrq_pkg.sv
`default_nettype none

package lprrq_pkg;

    // operation codes of an input beat; codes 5 to 7 mean nothing
    typedef enum logic [2:0] {
        OP_PUSH_BEGIN = 3'd0,
        OP_PUSH_BYTE  = 3'd1,
        OP_POP        = 3'd2,
        OP_PEEK       = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    // source of the record_length field of a result
    typedef enum logic [1:0] {
        LEN_ZERO,
        LEN_REQ,
        LEN_REC
    } t_len_sel;

    typedef struct packed {
        logic     latch_in;
        logic     do_clear;
        logic     push_wr;
        logic     hdr_wr;
        logic     hdr_done;
        logic     rd_start;
        logic     hdr_cap;
        logic     setup;
        logic     remove;
        logic     data_step;
        logic     emit;
        logic     res_ok;
        logic     res_data;
        t_len_sel len_sel;
        logic     res_last;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       push_open;
        logic       empty;
        logic       fits;
        logic       hcnt_last;
        logic       n_zero;
        logic       data_last;
    } t_stat;

endpackage

`default_nettype wire

>>> design/lprrq_ctrl.sv
`default_nettype none

module lprrq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                o_busy,
    input  wire lprrq_pkg::t_stat i_stat,
    output lprrq_pkg::t_cmd     o_cmd
);
    import lprrq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_HDR_WR,
        S_HDR_WAIT,
        S_HDR_CAP,
        S_SETUP,
        S_NODATA,
        S_DATA_WAIT,
        S_DATA_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.len_sel = LEN_ZERO;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state        = S_IDLE;
                o_cmd.res_last = 1'b1;
                if (i_stat.op == OP_PUSH_BYTE) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_ok  = i_stat.push_open;
                    o_cmd.push_wr = i_stat.push_open;
                end else if (i_stat.push_open) begin
                    o_cmd.emit = 1'b1;
                end else begin
                    case (i_stat.op)
                        OP_PUSH_BEGIN: begin
                            if (i_stat.fits) begin
                                n_state = S_HDR_WR;
                            end else begin
                                o_cmd.emit = 1'b1;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (i_stat.empty) begin
                                o_cmd.emit = 1'b1;
                            end else begin
                                o_cmd.rd_start = 1'b1;
                                n_state        = S_HDR_WAIT;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.do_clear = 1'b1;
                            o_cmd.emit     = 1'b1;
                            o_cmd.res_ok   = 1'b1;
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_HDR_WR: begin
                o_cmd.hdr_wr = 1'b1;
                if (i_stat.hcnt_last) begin
                    o_cmd.hdr_done = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.res_ok   = 1'b1;
                    o_cmd.len_sel  = LEN_REQ;
                    o_cmd.res_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_HDR_WAIT: begin
                n_state = S_HDR_CAP;
            end
            S_HDR_CAP: begin
                o_cmd.hdr_cap = 1'b1;
                n_state       = i_stat.hcnt_last ? S_SETUP : S_HDR_WAIT;
            end
            S_SETUP: begin
                o_cmd.setup  = 1'b1;
                o_cmd.remove = (i_stat.op == OP_POP);
                n_state      = i_stat.n_zero ? S_NODATA : S_DATA_WAIT;
            end
            S_NODATA: begin
                o_cmd.emit     = 1'b1;
                o_cmd.res_ok   = 1'b1;
                o_cmd.len_sel  = LEN_REC;
                o_cmd.res_last = 1'b1;
                n_state        = S_IDLE;
            end
            S_DATA_WAIT: begin
                n_state = S_DATA_EMIT;
            end
            S_DATA_EMIT: begin
                o_cmd.data_step = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.res_ok    = 1'b1;
                o_cmd.res_data  = 1'b1;
                o_cmd.len_sel   = LEN_REC;
                o_cmd.res_last  = i_stat.data_last;
                n_state         = i_stat.data_last ? S_IDLE : S_DATA_WAIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a data beat always follows its read wait cycle
    a_emit_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA_EMIT) |-> ($past(r_state) == S_DATA_WAIT))
        else $error("data beat without read wait");

    // an accepted start always lands in decode
    a_start_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !o_busy) |=> (r_state == S_EXEC))
        else $error("accepted item not decoded");

endmodule

`default_nettype wire

>>> design/lprrq_dp.sv
`default_nettype none

module lprrq_dp #(
    parameter int RING_BYTES   = 256,
    parameter int HEADER_BYTES = 2,
    parameter int MAX_RECORD   = 63
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [2:0]      i_opcode,
    input  wire logic [5:0]      i_length,
    input  wire logic [7:0]      i_in_byte,
    input  wire lprrq_pkg::t_cmd i_cmd,
    output lprrq_pkg::t_stat     o_stat,
    output logic                 o_res_strobe,
    output logic                 o_ok,
    output logic                 o_is_data,
    output logic [7:0]           o_out_byte,
    output logic [5:0]           o_record_length,
    output logic                 o_empty_res,
    output logic                 o_last
);
    import lprrq_pkg::*;

    localparam int PW  = $clog2(RING_BYTES);
    localparam int FW  = $clog2(RING_BYTES + 1);
    localparam int CW  = ((FW > 7) ? FW : 7) + 1;
    localparam int HCW = $clog2(HEADER_BYTES + 1);

    logic [7:0]     r_ring [RING_BYTES];
    logic [7:0]     r_rdata;

    logic [PW-1:0]  r_rp, r_wp, r_p;
    logic [PW-1:0]  n_rp, n_wp;
    logic [FW-1:0]  r_free, n_free;
    logic [5:0]     r_pr, n_pr;

    logic [2:0]     r_op;
    logic [5:0]     r_len;
    logic [7:0]     r_byte;
    logic [HCW-1:0] r_hcnt;
    logic [7:0]     r_hdr_lo;
    logic           r_hdr_hi;
    logic [5:0]     r_cnt;
    logic           r_valid;

    logic [5:0]     rec;
    logic [5:0]     n_out;
    logic [CW-1:0]  sum_rp;
    logic [CW-1:0]  sum_free;
    logic           wr_en;
    logic [PW-1:0]  wr_addr;
    logic [7:0]     wr_data;

    function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] p);
        if (p == PW'(RING_BYTES - 1)) begin
            return '0;
        end else begin
            return p + PW'(1);
        end
    endfunction

    // stored length, clamped; bytes to emit
    assign rec = (r_hdr_hi || (r_hdr_lo > 8'(MAX_RECORD))) ? 6'(MAX_RECORD)
                                                          : r_hdr_lo[5:0];
    assign n_out    = (rec < r_len) ? rec : r_len;
    assign sum_rp   = CW'(r_p) + CW'(rec);
    assign sum_free = CW'(r_free) + CW'(HEADER_BYTES) + CW'(rec);

    assign o_stat.op        = r_op;
    assign o_stat.push_open = (r_pr != 6'd0);
    assign o_stat.empty     = (r_free == FW'(RING_BYTES));
    assign o_stat.fits      = (r_len <= 6'(MAX_RECORD))
                           && (CW'(r_free) >= (CW'(r_len) + CW'(HEADER_BYTES)));
    assign o_stat.hcnt_last = (r_hcnt == HCW'(HEADER_BYTES - 1));
    assign o_stat.n_zero    = (n_out == 6'd0);
    assign o_stat.data_last = (r_cnt == (n_out - 6'd1));

    always_comb begin
        n_rp   = r_rp;
        n_wp   = r_wp;
        n_free = r_free;
        n_pr   = r_pr;
        if (i_cmd.do_clear) begin
            n_rp   = '0;
            n_wp   = '0;
            n_free = FW'(RING_BYTES);
        end
        if (i_cmd.push_wr) begin
            n_wp = f_adv(r_wp);
            n_pr = r_pr - 6'd1;
        end
        if (i_cmd.hdr_wr) begin
            n_wp = f_adv(r_wp);
        end
        if (i_cmd.hdr_done) begin
            n_free = r_free - FW'(r_len) - FW'(HEADER_BYTES);
            n_pr   = r_len;
        end
        if (i_cmd.setup && i_cmd.remove) begin
            n_rp   = (sum_rp >= CW'(RING_BYTES)) ? PW'(sum_rp - CW'(RING_BYTES))
                                                 : PW'(sum_rp);
            n_free = (sum_free > CW'(RING_BYTES)) ? FW'(RING_BYTES) : FW'(sum_free);
        end
    end

    // header bytes above the first are zero for a six-bit length
    assign wr_en   = i_cmd.push_wr || i_cmd.hdr_wr;
    assign wr_addr = r_wp;
    assign wr_data = i_cmd.push_wr ? r_byte
                   : ((r_hcnt == '0) ? {2'b00, r_len} : 8'h00);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= wr_data;
        end
        r_rdata <= r_ring[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_wp    <= '0;
            r_free  <= FW'(RING_BYTES);
            r_pr    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_free  <= n_free;
            r_pr    <= n_pr;
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op   <= i_opcode;
            r_len  <= i_length;
            r_byte <= i_in_byte;
            r_hcnt <= '0;
        end
        if (i_cmd.hdr_wr || i_cmd.hdr_cap) begin
            r_hcnt <= r_hcnt + HCW'(1);
        end
        if (i_cmd.rd_start) begin
            r_p      <= r_rp;
            r_hdr_hi <= 1'b0;
            r_cnt    <= '0;
        end
        if (i_cmd.hdr_cap) begin
            r_p <= f_adv(r_p);
            if (r_hcnt == '0) begin
                r_hdr_lo <= r_rdata;
            end else if (r_rdata != 8'h00) begin
                r_hdr_hi <= 1'b1;
            end
        end
        if (i_cmd.data_step) begin
            r_p   <= f_adv(r_p);
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_cmd.emit) begin
            o_ok        <= i_cmd.res_ok;
            o_is_data   <= i_cmd.res_data;
            o_out_byte  <= i_cmd.res_data ? r_rdata : 8'h00;
            o_empty_res <= (n_free == FW'(RING_BYTES));
            o_last      <= i_cmd.res_last;
            case (i_cmd.len_sel)
                LEN_REQ: o_record_length <= r_len;
                LEN_REC: o_record_length <= rec;
                default: o_record_length <= 6'd0;
            endcase
        end
    end

    assign o_res_strobe = r_valid;

    // an empty ring has both pointers together, outside a header write
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.hdr_wr && (r_free == FW'(RING_BYTES))) |-> (r_rp == r_wp))
        else $error("empty ring with pointers apart");

    // an open push holds reserved space
    a_push_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pr != 6'd0) |-> (r_free != FW'(RING_BYTES)))
        else $error("open push without reserved space");

    // a data beat is never a rejection
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_is_data) |-> o_ok)
        else $error("data beat flagged as rejected");

endmodule

`default_nettype wire

>>> design/length_prefixed_record_ring_queue.sv
`default_nettype none

// Length-prefixed record queue over a byte ring.
// Command channel: an item is taken on a rising edge with start high and busy
// low. Opcodes are push_begin, push_byte, pop, peek and clear.
// Result channel: each result beat is shown for one cycle with o_res_strobe
// high; o_last marks the final beat of an item. The receiver cannot stall,
// so every beat must be taken as it comes.
// Steps of each item:
//   push_byte, clear, rejections: busy through the decode state after the
//     accept edge, result in the next cycle.
//   push_begin: busy through the decode state and then the header writes,
//     one header byte written per cycle; the result follows in the next cycle.
//   pop/peek: busy through decode, a read wait and a capture per header byte,
//     setup, then a no-data result or a read wait and an emit per data byte;
//     the ring is a single memory with registered read, hence each wait.
// Reset (synchronous, active low) empties the queue and closes any open push;
// ring contents are not cleared and need no clearing pass.
module length_prefixed_record_ring_queue #(
    parameter int RING_BYTES   = 256,
    parameter int HEADER_BYTES = 2,
    parameter int MAX_RECORD   = 63
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_opcode,
    input  wire logic [5:0] i_length,
    input  wire logic [7:0] i_in_byte,
    output logic            o_res_strobe,
    output logic            o_ok,
    output logic            o_is_data,
    output logic [7:0]      o_out_byte,
    output logic [5:0]      o_record_length,
    output logic            o_empty_res,
    output logic            o_last
);
    import lprrq_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: decode, header walk, data walk
    lprrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: ring memory, pointers, free space, result registers
    lprrq_dp #(
        .RING_BYTES   (RING_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_RECORD   (MAX_RECORD)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (i_opcode),
        .i_length        (i_length),
        .i_in_byte       (i_in_byte),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_res_strobe    (o_res_strobe),
        .o_ok            (o_ok),
        .o_is_data       (o_is_data),
        .o_out_byte      (o_out_byte),
        .o_record_length (o_record_length),
        .o_empty_res     (o_empty_res),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
